### design/aes_pkg.sv
// Shared types, constant tables and byte-level round functions for the AES block.
// Used by aes_key_exp, aes_round_cell and aes_block_cipher_top; depends on nothing else.
package aes_pkg;

    localparam int MAX_ROUNDS = 14;
    localparam int NUM_RK     = MAX_ROUNDS + 1;
    localparam int NUM_WORDS  = 4 * NUM_RK;

    localparam logic [2:0] CFG_KEY_LEN = 3'd0;
    localparam logic [2:0] CFG_KEY_0   = 3'd1;
    localparam logic [2:0] CFG_KEY_1   = 3'd2;
    localparam logic [2:0] CFG_KEY_2   = 3'd3;
    localparam logic [2:0] CFG_KEY_3   = 3'd4;

    typedef logic [127:0] blk_t;

    typedef struct packed {
        logic valid;
        logic dec;
        logic err;
    } pipe_ctl_t;

    typedef struct packed {
        logic       ready;
        logic       bad;
        logic [3:0] nr;
    } key_st_t;

    localparam logic [7:0] RCON [16] = '{
        8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
        8'h80, 8'h1b, 8'h36, 8'h6c, 8'hd8, 8'hab, 8'h4d, 8'h00
    };

    localparam logic [7:0] SBOX_FWD [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiplication by a small constant in GF(2^8) modulo 0x11B.
    function automatic logic [7:0] gmul_c(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) acc = acc ^ x;
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
    endfunction

    // Byte i of the state sits in bits 127-8i down to 120-8i.
    function automatic blk_t byte_subst(input blk_t s, input logic inv);
        blk_t t;
        for (int i = 0; i < 16; i++)
            t[127-8*i -: 8] = inv ? SBOX_INV[s[127-8*i -: 8]] : SBOX_FWD[s[127-8*i -: 8]];
        return t;
    endfunction

    function automatic blk_t row_rotate(input blk_t s, input logic inv);
        blk_t t;
        int   src;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                src = inv ? (r + 4 * ((c + 4 - r) % 4)) : (r + 4 * ((c + r) % 4));
                t[127-8*(r+4*c) -: 8] = s[127-8*src -: 8];
            end
        end
        return t;
    endfunction

    function automatic blk_t mix_cols(input blk_t s, input logic inv);
        blk_t       t;
        logic [3:0] m [4];
        logic [7:0] acc;
        if (inv) begin
            m = '{4'he, 4'hb, 4'hd, 4'h9};
        end else begin
            m = '{4'h2, 4'h3, 4'h1, 4'h1};
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++)
                    acc = acc ^ gmul_c(s[127-8*(j+4*c) -: 8], m[(j - r + 4) % 4]);
                t[127-8*(r+4*c) -: 8] = acc;
            end
        end
        return t;
    endfunction

endpackage

### design/aes_key_exp.sv
// Configuration registers and the key expansion sequencer, one schedule word per cycle.
// Depends on aes_pkg; presents every round key in both encryption and decryption order.
module aes_key_exp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output aes_pkg::key_st_t    kst,
    output aes_pkg::blk_t       rk_enc [aes_pkg::NUM_RK],
    output aes_pkg::blk_t       rk_dec [aes_pkg::NUM_RK]
);

    logic [5:0]  len_reg;
    logic [63:0] key_reg [4];
    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [2:0]  sub_reg;
    logic [3:0]  rc_reg;
    logic [31:0] win_reg [8];
    logic [31:0] w_mem [aes_pkg::NUM_WORDS];

    logic        len_ok;
    logic [3:0]  nk;
    logic [3:0]  nr;
    logic [5:0]  last_idx;
    logic [255:0] key_all;
    logic [31:0] word;
    logic [31:0] temp;
    logic [31:0] back;
    logic        wr;

    assign cfg_ready = 1'b1;
    assign wr = cfg_valid && cfg_ready;
    assign len_ok = (len_reg == 6'd16) || (len_reg == 6'd24) || (len_reg == 6'd32);
    assign nk = len_reg[5:2];
    assign key_all = {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};

    always_comb begin
        case (len_reg)
            6'd24:   begin nr = 4'd12; last_idx = 6'd51; back = win_reg[5]; end
            6'd32:   begin nr = 4'd14; last_idx = 6'd59; back = win_reg[7]; end
            default: begin nr = 4'd10; last_idx = 6'd43; back = win_reg[3]; end
        endcase
    end

    always_comb begin
        temp = win_reg[0];
        if (sub_reg == 3'd0) begin
            temp = aes_pkg::sub_word({temp[23:0], temp[31:24]}) ^ {aes_pkg::RCON[rc_reg], 24'h0};
        end else if (nk == 4'd8 && sub_reg == 3'd4) begin
            temp = aes_pkg::sub_word(temp);
        end
        if (cnt_reg < {2'b00, nk}) begin
            word = key_all[255 - 32 * cnt_reg[2:0] -: 32];
        end else begin
            word = back ^ temp;
        end
    end

    // Any configuration write restarts the schedule from the first key word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= 6'd16;
            key_reg  <= '{default: 64'h0};
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            sub_reg  <= '0;
            rc_reg   <= '0;
        end else if (wr) begin
            case (cfg_index)
                aes_pkg::CFG_KEY_LEN: len_reg    <= cfg_data[5:0];
                aes_pkg::CFG_KEY_0:   key_reg[0] <= cfg_data;
                aes_pkg::CFG_KEY_1:   key_reg[1] <= cfg_data;
                aes_pkg::CFG_KEY_2:   key_reg[2] <= cfg_data;
                aes_pkg::CFG_KEY_3:   key_reg[3] <= cfg_data;
                default: ;
            endcase
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            sub_reg  <= '0;
            rc_reg   <= '0;
        end else if (busy_reg) begin
            if (!len_ok || cnt_reg == last_idx) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 6'd1;
            if (sub_reg == 3'(nk - 4'd1)) begin
                sub_reg <= '0;
                rc_reg  <= rc_reg + 4'd1;
            end else begin
                sub_reg <= sub_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && len_ok && !wr) begin
            w_mem[cnt_reg] <= word;
            win_reg[0] <= word;
            for (int k = 1; k < 8; k++) win_reg[k] <= win_reg[k-1];
        end
    end

    always_comb begin
        for (int r = 0; r < aes_pkg::NUM_RK; r++) begin
            rk_enc[r] = {w_mem[4*r], w_mem[4*r+1], w_mem[4*r+2], w_mem[4*r+3]};
        end
        for (int r = 0; r < aes_pkg::NUM_RK; r++) begin
            rk_dec[r] = '0;
            case (nr)
                4'd12: if (r <= 12) rk_dec[r] = rk_enc[12 - r];
                4'd14: if (r <= 14) rk_dec[r] = rk_enc[14 - r];
                default: if (r <= 10) rk_dec[r] = rk_enc[10 - r];
            endcase
        end
    end

    assign kst.ready = !busy_reg;
    assign kst.bad   = !len_ok;
    assign kst.nr    = nr;

endmodule

### design/aes_round_cell.sv
// One cipher round cell: forward or inverse round on its input block, then registered.
// Depends on aes_pkg; cells beyond the active round count pass the block through.
module aes_round_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [3:0]          round_idx,
    input  logic [3:0]          nr,
    input  aes_pkg::pipe_ctl_t  ctl_in,
    input  aes_pkg::blk_t       st_in,
    input  aes_pkg::blk_t       rk_e,
    input  aes_pkg::blk_t       rk_d,
    output aes_pkg::pipe_ctl_t  ctl_out,
    output aes_pkg::blk_t       st_out
);

    aes_pkg::pipe_ctl_t ctl_reg;
    aes_pkg::blk_t      st_reg;
    aes_pkg::blk_t      st_next;
    aes_pkg::blk_t      t;
    logic               last;

    assign last = (round_idx == nr);

    always_comb begin
        t = st_in;
        st_next = st_in;
        if (round_idx <= nr) begin
            if (!ctl_in.dec) begin
                t = aes_pkg::row_rotate(aes_pkg::byte_subst(st_in, 1'b0), 1'b0);
                if (!last) t = aes_pkg::mix_cols(t, 1'b0);
                st_next = t ^ rk_e;
            end else begin
                t = aes_pkg::byte_subst(aes_pkg::row_rotate(st_in, 1'b1), 1'b1) ^ rk_d;
                st_next = last ? t : aes_pkg::mix_cols(t, 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_in.valid;
        end
        if (en) begin
            ctl_reg.dec <= ctl_in.dec;
            ctl_reg.err <= ctl_in.err;
            st_reg      <= st_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign st_out  = st_reg;

endmodule

### design/aes_block_cipher_top.sv
// AES-128/192/256 block cipher: a row of fourteen round cells behind a key-addition stage.
// Depends on aes_pkg, aes_key_exp and aes_round_cell.
//
// Use: write the key length (register 0) and the key words (registers 1 to 4) over the
// cfg channel, one register per transaction. Each write restarts key expansion, which
// produces 44, 52 or 60 schedule words for 128, 192 or 256 bit keys; s_tready stays low meanwhile.
// After reset the block expands the all-zero 128-bit key in the same way.
// s_tdata carries one 128-bit block, s_tuser[0] selects decryption. Each accepted
// transaction yields one result on m_tdata, with m_tuser[0] flagging an invalid key
// length (data then zero). The path is the same whatever the key size: one key-addition
// stage plus fourteen round cells, the unused ones passing the block through.
// Throughput is one block per cycle while s_tready is high; directions mix freely.
// The last cell is the output register; when the receiver stalls with a result
// waiting, the whole row holds and s_tready drops until m_tready returns.
module aes_block_cipher_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_hi [63:0], block_lo [127:64]
    input  logic [0:0]   s_tuser,   // req_type [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_hi [63:0], result_lo [127:64]
    output logic [0:0]   m_tuser,   // key_error [0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int NC = aes_pkg::MAX_ROUNDS;

    aes_pkg::key_st_t   kst;
    aes_pkg::blk_t      rk_enc [aes_pkg::NUM_RK];
    aes_pkg::blk_t      rk_dec [aes_pkg::NUM_RK];
    aes_pkg::pipe_ctl_t ctl [NC + 1];
    aes_pkg::blk_t      st  [NC + 1];
    aes_pkg::pipe_ctl_t ctl0_reg;
    aes_pkg::blk_t      st0_reg;
    aes_pkg::blk_t      blk_in;
    logic               en;

    aes_key_exp u_key (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kst       (kst),
        .rk_enc    (rk_enc),
        .rk_dec    (rk_dec)
    );

    assign en       = !ctl[NC].valid || m_tready;
    assign s_tready = en && kst.ready;
    assign blk_in   = {s_tdata[63:0], s_tdata[127:64]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg.valid <= 1'b0;
        end else if (en) begin
            ctl0_reg.valid <= s_tvalid && s_tready;
        end
        if (en) begin
            ctl0_reg.dec <= s_tuser[0];
            ctl0_reg.err <= kst.bad;
            st0_reg      <= blk_in ^ (s_tuser[0] ? rk_dec[0] : rk_enc[0]);
        end
    end

    assign ctl[0] = ctl0_reg;
    assign st[0]  = st0_reg;

    for (genvar r = 1; r <= NC; r++) begin : g_cell
        aes_round_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .round_idx (4'(r)),
            .nr        (kst.nr),
            .ctl_in    (ctl[r-1]),
            .st_in     (st[r-1]),
            .rk_e      (rk_enc[r]),
            .rk_d      (rk_dec[r]),
            .ctl_out   (ctl[r]),
            .st_out    (st[r])
        );
    end

    assign m_tvalid   = ctl[NC].valid;
    assign m_tuser[0] = ctl[NC].err;
    assign m_tdata    = ctl[NC].err ? 128'h0 : {st[NC][63:0], st[NC][127:64]};

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 128'h0))
        else $error("key error result carries non-zero data");

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !s_tready)
        else $error("input accepted while key schedule restarts");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

endmodule

### tb/aes_block_cipher_top_tb.sv
// Self-checking testbench for aes_block_cipher_top: known-answer blocks, every key size and
// invalid key lengths, then random keys and blocks. Depends on aes_pkg and the design files.
`timescale 1ns / 1ps

class aes_scoreboard;
    bit [5:0]   key_len;
    bit [63:0]  key_word [4];
    bit [7:0]   sbox_f [256];
    bit [7:0]   sbox_i [256];
    bit [63:0]  exp_hi [$];
    bit [63:0]  exp_lo [$];
    bit         exp_err [$];
    int         errors;

    function new();
        bit [7:0] inv;
        bit [7:0] s;
        key_len = 6'd16;
        errors  = 0;
        foreach (key_word[k]) key_word[k] = '0;
        for (int v = 0; v < 256; v++) begin
            inv = 8'h01;
            repeat (254) inv = gf_mul(inv, v[7:0]);
            if (v == 0) inv = 8'h00;
            s = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
            sbox_f[v] = s;
        end
        for (int v = 0; v < 256; v++) sbox_i[sbox_f[v]] = v[7:0];
    endfunction

    function bit [7:0] rotl(bit [7:0] x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
        bit [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ a;
            a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
        end
        return r;
    endfunction

    function void write_reg(bit [2:0] idx, bit [63:0] d);
        if (idx == aes_pkg::CFG_KEY_LEN) key_len = d[5:0];
        else if (idx <= aes_pkg::CFG_KEY_3) key_word[idx - 1] = d;
    endfunction

    function bit [127:0] sub_state(bit [127:0] s, bit inv);
        for (int i = 0; i < 16; i++)
            s[127-8*i -: 8] = inv ? sbox_i[s[127-8*i -: 8]] : sbox_f[s[127-8*i -: 8]];
        return s;
    endfunction

    function bit [127:0] shift_state(bit [127:0] s, bit inv);
        bit [127:0] t;
        int src;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                src = r + 4 * ((inv ? (c + 4 - r) : (c + r)) % 4);
                t[127-8*(r+4*c) -: 8] = s[127-8*src -: 8];
            end
        return t;
    endfunction

    function bit [127:0] mix_state(bit [127:0] s, bit inv);
        bit [127:0] t;
        bit [7:0]   coef [4];
        bit [7:0]   acc;
        if (inv) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else     coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++)
                    acc = acc ^ gf_mul(coef[(j - r + 4) % 4], s[127-8*(j+4*c) -: 8]);
                t[127-8*(r+4*c) -: 8] = acc;
            end
        return t;
    endfunction

    // Full key expansion and cipher for one block under the current key registers.
    function void cipher(bit dec, bit [63:0] hi, bit [63:0] lo,
                         output bit [63:0] rhi, output bit [63:0] rlo, output bit err);
        bit [7:0]   w [60][4];
        bit [7:0]   tmp [4];
        bit [7:0]   t0;
        bit [7:0]   rc;
        bit [127:0] rk [15];
        bit [127:0] s;
        int nk, nr, total, idx;
        rhi = '0;
        rlo = '0;
        err = 1'b0;
        if (key_len != 16 && key_len != 24 && key_len != 32) begin
            err = 1'b1;
            return;
        end
        nk    = key_len / 4;
        nr    = nk + 6;
        total = 4 * (nr + 1);
        for (int i = 0; i < nk; i++)
            for (int j = 0; j < 4; j++) begin
                idx = 4 * i + j;
                w[i][j] = key_word[idx / 8][63 - 8 * (idx % 8) -: 8];
            end
        rc = 8'h01;
        for (int i = nk; i < total; i++) begin
            tmp = w[i-1];
            if (i % nk == 0) begin
                t0 = tmp[0];
                tmp[0] = sbox_f[tmp[1]] ^ rc;
                tmp[1] = sbox_f[tmp[2]];
                tmp[2] = sbox_f[tmp[3]];
                tmp[3] = sbox_f[t0];
                rc = rc[7] ? ({rc[6:0], 1'b0} ^ 8'h1b) : {rc[6:0], 1'b0};
            end else if (nk == 8 && i % nk == 4) begin
                for (int j = 0; j < 4; j++) tmp[j] = sbox_f[tmp[j]];
            end
            for (int j = 0; j < 4; j++) w[i][j] = w[i-nk][j] ^ tmp[j];
        end
        for (int i = 0; i <= nr; i++)
            for (int j = 0; j < 16; j++) rk[i][127-8*j -: 8] = w[4*i + j/4][j%4];
        s = {hi, lo};
        if (!dec) begin
            s = s ^ rk[0];
            for (int r = 1; r < nr; r++)
                s = mix_state(shift_state(sub_state(s, 0), 0), 0) ^ rk[r];
            s = shift_state(sub_state(s, 0), 0) ^ rk[nr];
        end else begin
            s = s ^ rk[nr];
            for (int r = nr - 1; r >= 1; r--)
                s = mix_state(sub_state(shift_state(s, 1), 1) ^ rk[r], 1);
            s = sub_state(shift_state(s, 1), 1) ^ rk[0];
        end
        rhi = s[127:64];
        rlo = s[63:0];
    endfunction

    function void note_input(bit dec, bit [63:0] hi, bit [63:0] lo);
        bit [63:0] rhi, rlo;
        bit        err;
        cipher(dec, hi, lo, rhi, rlo, err);
        exp_hi.push_back(rhi);
        exp_lo.push_back(rlo);
        exp_err.push_back(err);
    endfunction

    function void check_result(bit [63:0] hi, bit [63:0] lo, bit err);
        bit [63:0] ehi, elo;
        bit        eerr;
        if (exp_hi.size() == 0) begin
            $error("result transaction with nothing expected: %h %h %b", hi, lo, err);
            errors++;
            return;
        end
        ehi  = exp_hi.pop_front();
        elo  = exp_lo.pop_front();
        eerr = exp_err.pop_front();
        if (hi !== ehi) begin
            $error("result_hi expected %h actual %h", ehi, hi);
            errors++;
        end
        if (lo !== elo) begin
            $error("result_lo expected %h actual %h", elo, lo);
            errors++;
        end
        if (err !== eerr) begin
            $error("key_error expected %b actual %b", eerr, err);
            errors++;
        end
    endfunction

    function int pending();
        return exp_hi.size();
    endfunction
endclass

module aes_block_cipher_top_tb;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    aes_scoreboard sb = new();
    bit  idle_on = 1'b1;
    bit  long_hold_req = 1'b0;
    int  cycles = 0;

    aes_block_cipher_top dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 200000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Transactions on the input and result channels are observed at the edge where they complete.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input(s_tuser[0], s_tdata[63:0], s_tdata[127:64]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[63:0], m_tdata[127:64], m_tuser[0]);
    end

    // Receiver: short random stalls, plus one long hold-off that fills the pipeline.
    initial begin
        int  hold;
        bit  rdy;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                rdy = 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = 299;
                rdy = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 2);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    task automatic write_cfg(input logic [2:0] idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_key(input logic [5:0] len, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_cfg(aes_pkg::CFG_KEY_LEN, {58'd0, len});
        write_cfg(aes_pkg::CFG_KEY_0, k0);
        write_cfg(aes_pkg::CFG_KEY_1, k1);
        write_cfg(aes_pkg::CFG_KEY_2, k2);
        write_cfg(aes_pkg::CFG_KEY_3, k3);
    endtask

    // Leaves s_tvalid high after the handshake, so the next block can follow at once.
    task automatic send_block(input bit dec, input logic [63:0] hi, input logic [63:0] lo);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= dec;
        s_tdata  <= {lo, hi};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [5:0] len;
        int         pick;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // Default all-zero 128-bit key straight out of reset.
        send_block(0, '0, '0);
        send_block(1, '0, '0);
        send_block(0, '1, '1);
        send_block(1, '1, '1);
        send_block(0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        send_block(1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        drain();

        // Standard known-answer keys for each key size, both directions.
        load_key(6'd16, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        drain();
        load_key(6'd24, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
        send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        drain();
        load_key(6'd32, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        drain();

        // Invalid key lengths, extreme values included.
        write_cfg(aes_pkg::CFG_KEY_LEN, 64'd0);
        send_block(0, 64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();
        write_cfg(aes_pkg::CFG_KEY_LEN, 64'd20);
        send_block(1, 64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();
        write_cfg(aes_pkg::CFG_KEY_LEN, 64'd63);
        send_block(0, '1, '0);
        drain();

        // Only the low six bits of the length count; unused indexes are ignored.
        write_cfg(aes_pkg::CFG_KEY_LEN, 64'hffffffffffffffd0);
        write_cfg(3'd5, rand64());
        write_cfg(3'd6, rand64());
        write_cfg(3'd7, rand64());
        send_block(0, '0, '1);
        send_block(1, '1, '0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)      len = 6'd16;
            else if (pick < 6) len = 6'd24;
            else if (pick < 9) len = 6'd32;
            else               len = 6'($urandom_range(0, 63));
            if (ph == 0) len = 6'd32;
            load_key(len, rand64(), rand64(), rand64(), rand64());
            if ($urandom_range(0, 2) == 0) write_cfg(3'($urandom_range(5, 7)), rand64());
            if (ph == 2) long_hold_req = 1'b1;
            if (ph == 7) idle_on = 1'b0;
            for (int n = 0; n < 60; n++)
                send_block(1'($urandom_range(0, 1)), rand64(), rand64());
            drain();
        end

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
design/aes_pkg.sv
design/aes_key_exp.sv
design/aes_round_cell.sv
design/aes_block_cipher_top.sv
tb/aes_block_cipher_top_tb.sv
